>>> rtl/kwsm_pkg.sv
// Shared constants and types of the k-way sorted merge core.
`default_nettype none
package kwsm_pkg;

    localparam int CMD_W    = 1;
    localparam int SRC_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [CMD_W-1:0] CMD_HEAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_REPLY = 1'b1;

    // Register index of stream_count, taken from byte address bit 2.
    localparam logic REG_STREAM_COUNT = 1'b0;

    localparam logic [COUNT_W-1:0] STREAM_COUNT_RESET = 5'd16;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic insert;
        logic pop;
    } t_chain_op;

endpackage
`default_nettype wire

>>> rtl/kwsm_if.sv
// Valid/ready channel interfaces for input words and result words.
`default_nettype none
interface kwsm_in_if;
    import kwsm_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [SRC_W-1:0]   stream_index;
    logic               present;
    logic signed [VALUE_W-1:0] element_value;

    modport source (output valid, command, stream_index, present, element_value,
                    input ready);
    modport sink   (input valid, command, stream_index, present, element_value,
                    output ready);
endinterface

interface kwsm_out_if;
    import kwsm_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [VALUE_W-1:0] merged_value;
    logic [SRC_W-1:0]   source_stream;
    logic               done_res;

    modport source (output valid, merged_value, source_stream, done_res,
                    input ready);
    modport sink   (input valid, merged_value, source_stream, done_res,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/k_way_sorted_merge_core.sv
// Top level of the k-way sorted merge core: control, register port and cell row.
`default_nettype none
// Merges up to stream_count ascending streams into one ascending stream of
// result words. The pending stream heads live in a row of MAX_STREAMS cells
// kept in (key, stream) order, smallest at the head cell; an insertion is
// one parallel compare-and-shift of the whole row and a removal is one shift
// toward the head. During the load phase, command 0 words deliver each
// stream's first element or mark the stream empty. When the last head has
// arrived the smallest head is emitted with its stream index; that result is
// a request for the stream's next element, answered by a command 1 word that
// carries it or says the stream is exhausted. Words that do not fit the
// current phase, or reply for a stream other than the requested one, are
// taken and ignored. When the row runs empty a done result is emitted and the
// core returns to the load phase. An ignored word is only accepted, a head
// that does not yet start the merge is accepted and then inserted into the
// row, and a word that produces a result is accepted, inserted and then the
// head is removed into the output register; the removal waits while the
// output register is still held by an earlier result. One input word is in
// work at a time; no new word is taken until the last one is through. The
// stream_count register sits at byte address 0 and should be written only
// while no merge is in progress; values 0 act as 1 and values above
// MAX_STREAMS act as MAX_STREAMS.
module k_way_sorted_merge_core #(
    parameter int MAX_STREAMS = 16,
    parameter int KEY_BITS    = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    kwsm_in_if.sink                         i_in,
    kwsm_out_if.source                      o_out,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [kwsm_pkg::APB_AW-1:0]      paddr,
    input  wire [kwsm_pkg::APB_DW-1:0]      pwdata,
    output logic [kwsm_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import kwsm_pkg::*;

    localparam int CNT_W = $clog2(MAX_STREAMS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    // Configuration register.
    logic [COUNT_W-1:0] r_stream_count;
    logic [CNT_W-1:0]   w_active;

    // Control state.
    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_size;
    logic [CNT_W-1:0] r_heads;
    logic             r_merging;
    logic [SRC_W-1:0] r_awaited;

    // Word latched for the row.
    logic signed [KEY_BITS-1:0] r_new_key;
    logic [SRC_W-1:0]           r_new_src;
    logic                       r_do_ins;
    logic                       r_do_emit;

    // Output register.
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_out_value;
    logic [SRC_W-1:0]           r_out_src;
    logic                       r_out_done;

    logic                       w_accept;
    logic                       w_take;
    logic                       w_emit_now;
    logic                       w_pop_fire;
    logic signed [KEY_BITS-1:0] w_in_key;
    logic signed [VALUE_W-1:0]  w_head_value;
    t_chain_op                  w_op;

    logic                       w_lt  [MAX_STREAMS];
    logic signed [KEY_BITS-1:0] w_key [MAX_STREAMS];
    logic [SRC_W-1:0]           w_src [MAX_STREAMS];

    // ------------------------------------------------------------------
    // Register port. pready is tied high, so every access completes at once.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_count <= STREAM_COUNT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_STREAM_COUNT)) begin
            r_stream_count <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_STREAM_COUNT) begin
            prdata = {{(APB_DW-COUNT_W){1'b0}}, r_stream_count};
        end
    end

    // Effective stream count, clamped to the supported range.
    always_comb begin
        if (r_stream_count == '0) begin
            w_active = CNT_W'(1);
        end else if (32'(r_stream_count) > MAX_STREAMS) begin
            w_active = CNT_W'(MAX_STREAMS);
        end else begin
            w_active = CNT_W'(r_stream_count);
        end
    end

    // ------------------------------------------------------------------
    // Key conversion. A narrow key keeps the low bits of the element; a wide
    // key holds the 32-bit element zero-extended.
    // ------------------------------------------------------------------
    generate
        if (KEY_BITS <= VALUE_W) begin : g_narrow_key
            assign w_in_key     = i_in.element_value[KEY_BITS-1:0];
            assign w_head_value = VALUE_W'(w_key[0]);
        end else begin : g_wide_key
            assign w_in_key     = {{(KEY_BITS-VALUE_W){1'b0}}, i_in.element_value};
            assign w_head_value = w_key[0][VALUE_W-1:0];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Word acceptance and decode.
    // ------------------------------------------------------------------
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        if (!r_merging) begin
            w_take     = (i_in.command == CMD_HEAD) &&
                         (32'(i_in.stream_index) < 32'(w_active));
            w_emit_now = (32'(r_heads) + 32'd1) >= 32'(w_active);
        end else begin
            w_take     = (i_in.command == CMD_REPLY) &&
                         (i_in.stream_index == r_awaited);
            w_emit_now = 1'b1;
        end
    end

    assign w_pop_fire = (r_state == S_POP) && (!r_out_valid || o_out.ready);

    always_comb begin
        w_op.insert = (r_state == S_INS) && r_do_ins;
        w_op.pop    = w_pop_fire && (r_size != '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_take) begin
            r_new_key <= w_in_key;
            r_new_src <= i_in.stream_index;
            r_do_ins  <= i_in.present && (32'(r_size) < MAX_STREAMS);
            r_do_emit <= w_emit_now;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and phase bookkeeping.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_size    <= '0;
            r_heads   <= '0;
            r_merging <= 1'b0;
            r_awaited <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_take) begin
                        r_state <= S_INS;
                        if (!r_merging) begin
                            r_heads <= r_heads + CNT_W'(1);
                            if (w_emit_now) begin
                                r_merging <= 1'b1;
                            end
                        end
                    end
                end
                S_INS: begin
                    if (r_do_ins) begin
                        r_size <= r_size + CNT_W'(1);
                    end
                    r_state <= r_do_emit ? S_POP : S_IDLE;
                end
                S_POP: begin
                    if (w_pop_fire) begin
                        r_state <= S_IDLE;
                        if (r_size == '0) begin
                            // Merge finished: back to the load phase.
                            r_heads   <= '0;
                            r_merging <= 1'b0;
                            r_awaited <= '0;
                        end else begin
                            r_size    <= r_size - CNT_W'(1);
                            r_awaited <= w_src[0];
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register: one result word, held until the sink takes it.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_fire) begin
            if (r_size == '0) begin
                r_out_value <= '0;
                r_out_src   <= '0;
                r_out_done  <= 1'b1;
            end else begin
                r_out_value <= w_head_value;
                r_out_src   <= w_src[0];
                r_out_done  <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.merged_value  = r_out_value;
    assign o_out.source_stream = r_out_src;
    assign o_out.done_res      = r_out_done;

    // ------------------------------------------------------------------
    // Cell row. Cell 0 holds the smallest entry; each cell sees the insert
    // decision and entry of its left neighbor and the entry of its right one.
    // ------------------------------------------------------------------
    generate
        for (genvar g = 0; g < MAX_STREAMS; g++) begin : g_cell
            logic                       w_left_lt;
            logic signed [KEY_BITS-1:0] w_left_key;
            logic [SRC_W-1:0]           w_left_src;
            logic signed [KEY_BITS-1:0] w_right_key;
            logic [SRC_W-1:0]           w_right_src;

            if (g == 0) begin : g_head
                assign w_left_lt  = 1'b0;
                assign w_left_key = r_new_key;
                assign w_left_src = r_new_src;
            end else begin : g_mid
                assign w_left_lt  = w_lt[g-1];
                assign w_left_key = w_key[g-1];
                assign w_left_src = w_src[g-1];
            end

            if (g == MAX_STREAMS - 1) begin : g_tail
                assign w_right_key = '0;
                assign w_right_src = '0;
            end else begin : g_inner
                assign w_right_key = w_key[g+1];
                assign w_right_src = w_src[g+1];
            end

            kwsm_cell #(
                .INDEX    (g),
                .KEY_BITS (KEY_BITS),
                .CNT_W    (CNT_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_op        (w_op),
                .i_size      (r_size),
                .i_new_key   (r_new_key),
                .i_new_src   (r_new_src),
                .i_left_lt   (w_left_lt),
                .i_left_key  (w_left_key),
                .i_left_src  (w_left_src),
                .i_right_key (w_right_key),
                .i_right_src (w_right_src),
                .o_lt        (w_lt[g]),
                .o_key       (w_key[g]),
                .o_src       (w_src[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_size) <= MAX_STREAMS)
        else $error("fill count exceeds the cell row");

    a_done_on_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_fire && (r_size == '0)) |=> (r_out_valid && r_out_done && !r_merging))
        else $error("done result not produced on an empty row");

    a_request_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_fire && (r_size != '0)) |=>
            (r_out_valid && !r_out_done && (r_awaited == r_out_src) && r_merging))
        else $error("awaited stream does not match the emitted word");

    a_op_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.insert |-> (!w_op.pop && !i_in.ready))
        else $error("row insert overlaps a removal or an acceptance");

endmodule
`default_nettype wire

>>> rtl/kwsm_cell.sv
// One cell of the sorted priority row: holds one entry and shifts with its neighbors.
`default_nettype none
module kwsm_cell #(
    parameter int INDEX    = 0,
    parameter int KEY_BITS = 32,
    parameter int CNT_W    = 5
) (
    input  wire                               i_clk,
    input  wire kwsm_pkg::t_chain_op          i_op,
    input  wire [CNT_W-1:0]                   i_size,
    input  wire signed [KEY_BITS-1:0]         i_new_key,
    input  wire [kwsm_pkg::SRC_W-1:0]         i_new_src,
    input  wire                               i_left_lt,
    input  wire signed [KEY_BITS-1:0]         i_left_key,
    input  wire [kwsm_pkg::SRC_W-1:0]         i_left_src,
    input  wire signed [KEY_BITS-1:0]         i_right_key,
    input  wire [kwsm_pkg::SRC_W-1:0]         i_right_src,
    output logic                              o_lt,
    output logic signed [KEY_BITS-1:0]        o_key,
    output logic [kwsm_pkg::SRC_W-1:0]        o_src
);
    import kwsm_pkg::*;

    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic [SRC_W-1:0]           r_src, n_src;
    logic                       w_occupied;

    // The row is filled from the head, so occupancy follows from the fill count.
    assign w_occupied = (INDEX < 32'(i_size));

    // True when the new entry must sit before this cell's entry.
    assign o_lt = !w_occupied || (i_new_key < r_key) ||
                  ((i_new_key == r_key) && (i_new_src < r_src));

    always_comb begin
        n_key = r_key;
        n_src = r_src;
        if (i_op.insert && o_lt) begin
            if (i_left_lt) begin
                n_key = i_left_key;
                n_src = i_left_src;
            end else begin
                n_key = i_new_key;
                n_src = i_new_src;
            end
        end else if (i_op.pop) begin
            n_key = i_right_key;
            n_src = i_right_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_src <= n_src;
    end

    assign o_key = r_key;
    assign o_src = r_src;

endmodule
`default_nettype wire
